// ===== hdl/rpcd_pkg.sv =====
// Shared types and constants for the RPC frame deframer.
package rpcd_pkg;

  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned CountW      = 4;
  localparam logic [31:0] ReplyMethod = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [1:0] CfgServerPresent = 2'd0;
  localparam logic [1:0] CfgClientPresent = 2'd1;
  localparam logic [1:0] CfgMethodCount   = 2'd2;

  typedef enum logic [1:0] {
    KindRequest = 2'd0,
    KindReply   = 2'd1,
    KindPayload = 2'd2,
    KindError   = 2'd3
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] method_num;
    logic [31:0] payload_length;
    logic [31:0] request_tag;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic        server_present;
    logic        client_present;
    logic [31:0] method_count;
  } cfg_t;

endpackage

// ===== hdl/rpcd_parse.sv =====
// Frame parser: header assembly, frame classification and payload count.
module rpcd_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpcd_pkg::cfg_t   cfg_i,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output rpcd_pkg::result_t res_o
);
  import rpcd_pkg::*;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhFailed  = 2'd2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [31:0]         method_q, method_d;
  logic [31:0]         length_q, length_d;
  logic [31:0]         id_q, id_d;
  logic [31:0]         remain_q, remain_d;
  logic [1:0]          lane;
  logic                hdr_done;
  logic                is_reply;
  logic                frame_ok;

  assign lane     = count_q[1:0];
  assign hdr_done = (count_q == CountW'(HeaderBytes - 1));
  assign is_reply = (method_q == ReplyMethod);
  assign frame_ok = is_reply ? cfg_i.client_present
                             : (cfg_i.server_present && (method_q < cfg_i.method_count));

  // Next state and result for the incoming byte
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    method_d    = method_q;
    length_d    = length_q;
    id_d        = id_q;
    remain_d    = remain_q;
    res_valid_o = 1'b0;
    res_o.kind           = KindPayload;
    res_o.payload_byte   = 8'd0;
    res_o.last_of_frame  = 1'b0;

    case (phase_q)
      PhHeader: begin
        if (count_q < CountW'(4)) begin
          method_d[lane*8 +: 8] = byte_i;
        end else if (count_q < CountW'(8)) begin
          length_d[lane*8 +: 8] = byte_i;
        end else begin
          id_d[lane*8 +: 8] = byte_i;
        end
        count_d = count_q + CountW'(1);
        if (hdr_done) begin
          count_d     = '0;
          res_valid_o = 1'b1;
          if (!frame_ok) begin
            phase_d    = PhFailed;
            res_o.kind = KindError;
          end else begin
            res_o.kind = is_reply ? KindReply : KindRequest;
            if (length_q == 32'd0) begin
              phase_d             = PhHeader;
              res_o.last_of_frame = 1'b1;
            end else begin
              phase_d  = PhPayload;
              remain_d = length_q;
            end
          end
        end
      end
      PhPayload: begin
        res_valid_o         = 1'b1;
        res_o.kind          = KindPayload;
        res_o.payload_byte  = byte_i;
        res_o.last_of_frame = (remain_q <= 32'd1);
        if (remain_q <= 32'd1) begin
          remain_d = '0;
          phase_d  = PhHeader;
          count_d  = '0;
        end else begin
          remain_d = remain_q - 32'd1;
        end
      end
      default: begin
        // failed: drop everything
        res_valid_o = 1'b0;
      end
    endcase

    // only the request id byte can change on the last header byte
    res_o.method_num     = method_q;
    res_o.payload_length = length_q;
    res_o.request_tag    = id_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      count_q  <= '0;
      method_q <= '0;
      length_q <= '0;
      id_q     <= '0;
      remain_q <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      method_q <= method_d;
      length_q <= length_d;
      id_q     <= id_d;
      remain_q <= remain_d;
    end
  end

endmodule

// ===== hdl/rpc_frame_deframer.sv =====
// Top level of the RPC frame deframer: config registers, parser and output buffering.
// A result is registered in the output stage, or in the skid stage while the
// output is stalled; a full skid stage holds the slave side not ready. One byte
// per cycle otherwise; the parser's next state is a single counter/compare step.
// Reset (asynchronous, active low): header phase, counts cleared, server and client
// present, method count zero; no request in flight.
module rpc_frame_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration write port
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  // slave side
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] byte_in
  // master side
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // [31:0] method_num, [63:32] payload_length,
                                        // [95:64] request_tag, [103:96] payload_byte
  output logic [1:0]    m_axis_tuser,   // [1:0] result_kind
  output logic          m_axis_tlast    // last_of_frame
);
  import rpcd_pkg::*;

  cfg_t    cfg_q;
  logic    accept;
  logic    res_valid;
  result_t res;
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.server_present <= 1'b1;
      cfg_q.client_present <= 1'b1;
      cfg_q.method_count   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgServerPresent: cfg_q.server_present <= cfg_data_i[0];
        CfgClientPresent: cfg_q.client_present <= cfg_data_i[0];
        CfgMethodCount:   cfg_q.method_count   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_take      = out_valid_q && m_axis_tready;

  rpcd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (!out_valid_q || out_take) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the output and skid stages
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_valid_q || out_take) begin
        out_q <= skid_q;
      end
    end else if (accept && res_valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.payload_byte, out_q.request_tag,
                          out_q.payload_length, out_q.method_num};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last_of_frame;

endmodule
